// ===== hw/rtl/hbm_pkg.sv =====
`timescale 1ns / 1ps
package hbm_pkg;

  localparam int ADDR_BITS  = 48;
  localparam int PORT_BITS  = 6;
  localparam int BANK_BITS  = 6;
  localparam int MAX_STAGE  = 6;
  localparam int MAX_BANKS  = 64;
  localparam int FOLD_SPAN  = 32;
  localparam int LOW_W      = 31;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = ADDR_BITS / DIV_STEP;
  localparam int NUM_STAGES = 4 + DIV_STAGES + 1;

  typedef enum logic [2:0] {
    REG_IL, REG_SB, REG_NODE, REG_ALIAS, REG_XOR, REG_ODD, REG_BANKS
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0]           il;
    logic [2:0]           sb;
    logic [ADDR_BITS-1:0] node_span;
    logic [6:0]           alias_f;
    logic                 xor_en;
    logic                 odd_en;
    logic [6:0]           bank_count;
  } cfg_t;

  typedef struct packed {
    logic [BANK_BITS-1:0] bank;
    logic [ADDR_BITS-1:0] boff;
    logic [LOW_W-1:0]     low;
  } side_t;

  // bank field width: configured field width, or floor(log2(bank_count)) when zero, capped
  function automatic logic [2:0] eff_sb(cfg_t c);
    logic [2:0] s;
    s = c.sb;
    if (s == 3'd0) begin
      s = 3'd0;
      for (int i = 1; i < 7; i++) begin
        if (c.bank_count[i]) s = 3'(i);
      end
    end
    if (s > 3'(MAX_STAGE)) s = 3'(MAX_STAGE);
    return s;
  endfunction

  function automatic logic [BANK_BITS-1:0] odd_div(cfg_t c);
    logic [6:0] n;
    n = c.bank_count;
    if (n < 7'd2) n = 7'd2;
    if (n > 7'(MAX_BANKS)) n = 7'(MAX_BANKS);
    return BANK_BITS'(n - 7'd1);
  endfunction

endpackage

// ===== hw/rtl/hbm_addr.sv =====
`timescale 1ns / 1ps
module hbm_addr (
  input  logic                          clk,
  input  logic [2:0]                    en,
  input  hbm_pkg::cfg_t                 cfg,
  input  logic [hbm_pkg::ADDR_BITS-1:0] address,
  input  logic [hbm_pkg::PORT_BITS-1:0] port_index,
  output logic [hbm_pkg::ADDR_BITS-1:0] addr_out
);
  import hbm_pkg::*;

  logic [ADDR_BITS-1:0] addr0_r, addr1_r, addr2_r, span0_r, prod1_r;
  logic [ADDR_BITS-1:0] addr0_nxt, span0_nxt, prod1_nxt, addr2_nxt;
  logic [PORT_BITS-1:0] qport0_r, qport0_nxt;
  logic [PORT_BITS-1:0] q;
  logic [7:0]           rem;
  logic [ADDR_BITS+6:0] span_wide;
  logic [ADDR_BITS+5:0] prod_wide;

  // port / alias by restoring steps, node span times alias
  always_comb begin
    rem = '0;
    q   = '0;
    for (int i = PORT_BITS - 1; i >= 0; i--) begin
      rem = {rem[6:0], port_index[i]};
      if (rem >= {1'b0, cfg.alias_f}) begin
        rem  = rem - {1'b0, cfg.alias_f};
        q[i] = 1'b1;
      end
    end
    span_wide = cfg.node_span * cfg.alias_f;
    addr0_nxt = address;
    if (cfg.alias_f > 7'd1) begin
      qport0_nxt = q;
      span0_nxt  = span_wide[ADDR_BITS-1:0];
    end else begin
      qport0_nxt = port_index;
      span0_nxt  = cfg.node_span;
    end
  end

  assign prod_wide = qport0_r * span0_r;
  assign prod1_nxt = prod_wide[ADDR_BITS-1:0];
  assign addr2_nxt = addr1_r + prod1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      addr0_r  <= addr0_nxt;
      qport0_r <= qport0_nxt;
      span0_r  <= span0_nxt;
    end
    if (en[1]) begin
      addr1_r <= addr0_r;
      prod1_r <= prod1_nxt;
    end
    if (en[2]) addr2_r <= addr2_nxt;
  end

  assign addr_out = addr2_r;
endmodule

// ===== hw/rtl/hbm_map.sv =====
`timescale 1ns / 1ps
module hbm_map (
  input  logic                          clk,
  input  logic                          en,
  input  hbm_pkg::cfg_t                 cfg,
  input  logic [hbm_pkg::ADDR_BITS-1:0] addr,
  output logic [hbm_pkg::ADDR_BITS-1:0] upper,
  output hbm_pkg::side_t                side
);
  import hbm_pkg::*;

  logic [ADDR_BITS-1:0] upper_r, upper_nxt, hi, low_mask;
  side_t                side_r, side_nxt;
  logic [2:0]           sb;
  logic [BANK_BITS-1:0] bmask, bank;
  logic [5:0]           shift, lim;
  logic [ADDR_BITS-1:0] chunk;

  always_comb begin
    sb        = eff_sb(cfg);
    bmask     = BANK_BITS'((7'd1 << sb) - 7'd1);
    upper_nxt = addr >> cfg.il;
    bank      = upper_nxt[BANK_BITS-1:0] & bmask;
    lim       = 6'(FOLD_SPAN - 1) - {1'b0, cfg.il};
    // fold count is (31 - il) / sb: lane i joins while i * sb fits in the span
    for (int i = 1; i < FOLD_SPAN; i++) begin
      shift = 6'(i) * {3'd0, sb};
      chunk = upper_nxt >> shift;
      if (cfg.xor_en && sb != 3'd0 && i * int'(sb) <= int'(lim))
        bank = bank ^ chunk[BANK_BITS-1:0];
    end
    bank          = bank & bmask;
    low_mask      = (ADDR_BITS'(1) << cfg.il) - ADDR_BITS'(1);
    hi            = (addr >> ({3'd0, sb} + {1'b0, cfg.il})) << cfg.il;
    side_nxt.bank = bank;
    side_nxt.low  = LOW_W'(addr & low_mask);
    side_nxt.boff = hi | (addr & low_mask);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      upper_r <= upper_nxt;
      side_r  <= side_nxt;
    end
  end

  assign upper = upper_r;
  assign side  = side_r;
endmodule

// ===== hw/rtl/hbm_div.sv =====
`timescale 1ns / 1ps
module hbm_div (
  input  logic                           clk,
  input  logic [hbm_pkg::DIV_STAGES-1:0] en,
  input  logic [hbm_pkg::BANK_BITS-1:0]  divisor,
  input  logic [hbm_pkg::ADDR_BITS-1:0]  qd_in,
  input  hbm_pkg::side_t                 side_in,
  output logic [hbm_pkg::ADDR_BITS-1:0]  quot,
  output logic [hbm_pkg::BANK_BITS-1:0]  rem_out,
  output hbm_pkg::side_t                 side_out
);
  import hbm_pkg::*;

  // qd holds the dividend bits still to consume on top, quotient bits below
  logic [ADDR_BITS-1:0] qd_r   [DIV_STAGES];
  logic [BANK_BITS-1:0] rem_r  [DIV_STAGES];
  side_t                side_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
    logic [ADDR_BITS-1:0] qd_cur, qd_nxt;
    logic [BANK_BITS-1:0] rem_cur;
    side_t                side_cur;
    logic [BANK_BITS:0]   r;

    if (j == 0) begin : g_first
      assign qd_cur   = qd_in;
      assign rem_cur  = '0;
      assign side_cur = side_in;
    end else begin : g_next
      assign qd_cur   = qd_r[j-1];
      assign rem_cur  = rem_r[j-1];
      assign side_cur = side_r[j-1];
    end

    always_comb begin
      r      = {1'b0, rem_cur};
      qd_nxt = qd_cur;
      for (int s = 0; s < DIV_STEP; s++) begin
        r      = {r[BANK_BITS-1:0], qd_nxt[ADDR_BITS-1]};
        qd_nxt = {qd_nxt[ADDR_BITS-2:0], 1'b0};
        if (r >= {1'b0, divisor}) begin
          r         = r - {1'b0, divisor};
          qd_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        qd_r[j]   <= qd_nxt;
        rem_r[j]  <= r[BANK_BITS-1:0];
        side_r[j] <= side_cur;
      end
    end
  end

  assign quot     = qd_r[DIV_STAGES-1];
  assign rem_out  = rem_r[DIV_STAGES-1];
  assign side_out = side_r[DIV_STAGES-1];
endmodule

// ===== hw/rtl/hbm_bank_address_mapper.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_address, in_port_index
// out     | output    | out_valid / out_ready | out_bank_index, out_bank_address
// cfg     | input     | cfg_we                | cfg_index, cfg_wdata
// One word per cycle sustained while out_ready holds; three address stages
// (port divide and span multiply, port times span, add), one bank/hash stage,
// twelve stages of the bank-count divider at four bits each, one output stage.
// Synchronous active-low reset clears valid bits and loads the default configuration.
// Each stage takes a new word when empty or when the next stage moves, so
// bubbles collapse and a stall on out holds every word in place.
`timescale 1ns / 1ps
module hbm_bank_address_mapper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hbm_pkg::ADDR_BITS-1:0] in_address,
  input  logic [hbm_pkg::PORT_BITS-1:0] in_port_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbm_pkg::BANK_BITS-1:0] out_bank_index,
  output logic [hbm_pkg::ADDR_BITS-1:0] out_bank_address,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [hbm_pkg::ADDR_BITS-1:0] cfg_wdata
);
  import hbm_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  cfg_t                  cfg_r;
  logic [NUM_STAGES-1:0] v_r, v_nxt;
  logic [NUM_STAGES:0]   en;
  logic [ADDR_BITS-1:0]  addr_s2, upper_s3, quot;
  side_t                 side_s3, side_d;
  logic [BANK_BITS-1:0]  rem_d;
  logic [BANK_BITS-1:0]  bank_r, bank_nxt;
  logic [ADDR_BITS-1:0]  boff_r, boff_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{il: 5'd0, sb: 3'd0, node_span: '0, alias_f: 7'd1,
                 xor_en: 1'b0, odd_en: 1'b0, bank_count: 7'd2};
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_IL:    cfg_r.il         <= cfg_wdata[4:0];
        REG_SB:    cfg_r.sb         <= cfg_wdata[2:0];
        REG_NODE:  cfg_r.node_span  <= cfg_wdata;
        REG_ALIAS: cfg_r.alias_f    <= cfg_wdata[6:0];
        REG_XOR:   cfg_r.xor_en     <= cfg_wdata[0];
        REG_ODD:   cfg_r.odd_en     <= cfg_wdata[0];
        REG_BANKS: cfg_r.bank_count <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_valid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = en[0];

  hbm_addr u_addr (
    .clk        (clk),
    .en         (en[2:0]),
    .cfg        (cfg_r),
    .address    (in_address),
    .port_index (in_port_index),
    .addr_out   (addr_s2)
  );

  hbm_map u_map (
    .clk   (clk),
    .en    (en[3]),
    .cfg   (cfg_r),
    .addr  (addr_s2),
    .upper (upper_s3),
    .side  (side_s3)
  );

  hbm_div u_div (
    .clk      (clk),
    .en       (en[4 +: DIV_STAGES]),
    .divisor  (odd_div(cfg_r)),
    .qd_in    (upper_s3),
    .side_in  (side_s3),
    .quot     (quot),
    .rem_out  (rem_d),
    .side_out (side_d)
  );

  always_comb begin
    if (cfg_r.odd_en) begin
      bank_nxt = rem_d;
      boff_nxt = (quot << cfg_r.il) | {{(ADDR_BITS-LOW_W){1'b0}}, side_d.low};
    end else begin
      bank_nxt = side_d.bank;
      boff_nxt = side_d.boff;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      bank_r <= bank_nxt;
      boff_r <= boff_nxt;
    end
  end

  assign out_valid        = v_r[LAST];
  assign out_bank_index   = bank_r;
  assign out_bank_address = boff_r;

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready) else $error("input stalled while output drains");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready)) else $error("stall without output block");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("word out of reset");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import hbm_pkg::*;

  localparam int LATENCY = 17;
  localparam int STALL_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ADDR_BITS-1:0] in_address = '0;
  logic [PORT_BITS-1:0] in_port_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BANK_BITS-1:0] out_bank_index;
  logic [ADDR_BITS-1:0] out_bank_address;
  logic                 cfg_we = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [ADDR_BITS-1:0] cfg_wdata = '0;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [PORT_BITS-1:0] port;
  } req_t;

  typedef struct packed {
    logic [BANK_BITS-1:0] bank;
    logic [ADDR_BITS-1:0] boff;
  } map_t;

  req_t req_q[$];
  map_t mapped_q[$];

  // shadow of the mapper registers
  logic [4:0]           m_il;
  logic [2:0]           m_sb;
  logic [ADDR_BITS-1:0] m_node;
  logic [6:0]           m_alias;
  logic                 m_xor;
  logic                 m_odd;
  logic [6:0]           m_banks;

  int  errors = 0;
  int  idle_cnt = 0;
  int  in_wait = 0;
  int  out_wait = 0;
  logic [31:0] sent = 0;
  logic [31:0] accepted = 0;

  hbm_bank_address_mapper u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic map_t map_request(req_t r);
    map_t m;
    logic [63:0] addr, port, span, chunk, bmask, lmask, bank, boff, upper, dv;
    int sb, il, folds;
    il = m_il;
    sb = m_sb;
    if (sb == 0) begin
      for (int i = 1; i < 7; i++) if (m_banks >= (7'd1 << i)) sb = i;
    end
    if (sb > MAX_STAGE) sb = MAX_STAGE;
    port = r.port;
    span = m_node;
    if (m_alias > 1) begin
      port = port / m_alias;
      span = span * m_alias;
    end
    addr = (64'(r.addr) + port * span) & 64'hFFFF_FFFF_FFFF;
    bmask = (64'd1 << sb) - 1;
    lmask = (64'd1 << il) - 1;
    bank = (addr >> il) & bmask;
    if (m_xor && sb > 0) begin
      chunk = addr >> (sb + il);
      folds = (FOLD_SPAN - 1 - il) / sb;
      for (int i = 0; i < folds; i++) begin
        bank ^= chunk;
        chunk >>= sb;
      end
      bank &= bmask;
    end
    boff = ((addr >> (sb + il)) << il) + (addr & lmask);
    if (m_odd) begin
      dv = m_banks < 2 ? 2 : (m_banks > MAX_BANKS ? MAX_BANKS : m_banks);
      dv = dv - 1;
      upper = addr >> il;
      bank = upper % dv;
      boff = ((upper / dv) << il) + (addr & lmask);
    end
    m.bank = bank[BANK_BITS-1:0];
    m.boff = boff[ADDR_BITS-1:0];
    return m;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [ADDR_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_IL:    m_il = val[4:0];
      REG_SB:    m_sb = val[2:0];
      REG_NODE:  m_node = val;
      REG_ALIAS: m_alias = val[6:0];
      REG_XOR:   m_xor = val[0];
      REG_ODD:   m_odd = val[0];
      default:   m_banks = val[6:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block until the pipe has drained, plus the latency for safety
  task automatic drain();
    wait (sent == accepted && accepted == sent && mapped_q.size() == 0 &&
          req_q.size() == 0 && !in_valid);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic push_req(logic [ADDR_BITS-1:0] a, logic [PORT_BITS-1:0] p);
    req_t r;
    r.addr = a;
    r.port = p;
    req_q.push_back(r);
    sent = sent + 1;
  endtask

  task automatic rand_cfg(bit extreme);
    write_reg(REG_IL, ADDR_BITS'(extreme ? ($urandom_range(0, 1) ? 24 : 0)
                                         : $urandom_range(0, 31)));
    write_reg(REG_SB, ADDR_BITS'($urandom_range(0, 7)));
    write_reg(REG_NODE, ADDR_BITS'(extreme ? ($urandom_range(0, 1) ? '1 : '0)
                                : {$urandom, $urandom} >> $urandom_range(0, 40)));
    write_reg(REG_ALIAS, ADDR_BITS'(extreme ? ($urandom_range(0, 1) ? 64 : 127)
                                            : $urandom_range(0, 127)));
    write_reg(REG_XOR, ADDR_BITS'($urandom_range(0, 1)));
    write_reg(REG_ODD, ADDR_BITS'($urandom_range(0, 1)));
    write_reg(REG_BANKS, ADDR_BITS'(extreme ? ($urandom_range(0, 1) ? 64 : 0)
                                            : $urandom_range(0, 127)));
  endtask

  task automatic rand_reqs(int n);
    for (int i = 0; i < n; i++)
      push_req(ADDR_BITS'({$urandom, $urandom} >> $urandom_range(0, 16)),
               PORT_BITS'($urandom_range(0, 63)));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        accepted <= accepted + 1;
        mapped_q.push_back(map_request('{in_address, in_port_index}));
      end
      if (!in_valid || in_ready) begin
        if (in_valid && in_ready) in_wait = $urandom_range(0, 3);
        if (in_wait > 0 || req_q.size() == 0) begin
          if (in_wait > 0) in_wait--;
          in_valid <= 1'b0;
        end else begin
          req_t r;
          r = req_q.pop_front();
          in_valid <= 1'b1;
          in_address <= r.addr;
          in_port_index <= r.port;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (mapped_q.size() == 0) begin
          $error("unexpected word: bank %0d addr %h", out_bank_index, out_bank_address);
          errors++;
        end else begin
          map_t e;
          e = mapped_q.pop_front();
          if (out_bank_index !== e.bank) begin
            $error("bank_index exp %0d got %0d", e.bank, out_bank_index);
            errors++;
          end
          if (out_bank_address !== e.boff) begin
            $error("bank_address exp %h got %h", e.boff, out_bank_address);
            errors++;
          end
        end
        out_wait = $urandom_range(0, 3);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    m_il = 0; m_sb = 0; m_node = '0; m_alias = 1; m_xor = 0; m_odd = 0; m_banks = 2;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: reset config, then extremes
    push_req('0, 0);
    push_req('1, 63);
    push_req(48'hAAAA_AAAA_AAAA, 21);
    push_req(48'h5555_5555_5555, 42);
    drain();
    write_reg(REG_IL, 24);
    write_reg(REG_SB, 6);
    write_reg(REG_NODE, '1);
    write_reg(REG_ALIAS, 0);
    write_reg(REG_XOR, 1);
    write_reg(REG_ODD, 0);
    write_reg(REG_BANKS, 127);
    push_req('1, 63);
    push_req(48'h0000_FFFF_FFFF, 1);
    push_req('0, 0);
    drain();
    write_reg(REG_IL, 0);
    write_reg(REG_SB, 7);
    write_reg(REG_ALIAS, 64);
    write_reg(REG_ODD, 1);
    write_reg(REG_BANKS, 0);
    push_req('1, 63);
    push_req(48'h1234_5678_9ABC, 7);
    drain();
    write_reg(REG_SB, 0);
    drain();
    write_reg(REG_BANKS, 3);
    write_reg(REG_ALIAS, 127);
    write_reg(REG_XOR, 1);
    write_reg(REG_ODD, 0);
    push_req('1, 63);
    push_req(48'hFFFF_0000_0001, 32);
    drain();
    // random phases, extremes in every third one
    for (int ph = 0; ph < 12; ph++) begin
      rand_cfg(ph % 3 == 0);
      rand_reqs(48);
      drain();
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0 && mapped_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hbm_pkg.sv
hw/rtl/hbm_addr.sv
hw/rtl/hbm_map.sv
hw/rtl/hbm_div.sv
hw/rtl/hbm_bank_address_mapper.sv
tb/testbench.sv
